// ===== hw/rtl/rcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// RC pulse decoder package
// Widths, codes, reset values and constants shared by the decoder files.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned DIGIT_W    = 2;
  localparam int unsigned NUM_DIGITS = STAMP_W / DIGIT_W;
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS);

  localparam int unsigned US_W       = 12;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned OFF_W      = 13;
  localparam int unsigned MUL_W      = US_W + PCT_W;
  localparam int unsigned DIV_CNT_W  = $clog2(PCT_W);

  // opcodes
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // channels
  localparam logic [CH_W-1:0] CH_FORBACK   = 2'd0;
  localparam logic [CH_W-1:0] CH_LEFTRIGHT = 2'd1;
  localparam logic [CH_W-1:0] CH_THROTTLE  = 2'd2;

  // forward/back classes
  localparam logic [1:0] CLS_NEUTRAL  = 2'd0;
  localparam logic [1:0] CLS_FORWARD  = 2'd1;
  localparam logic [1:0] CLS_BACKWARD = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_FB   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_THRESH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LR   = 3'd7;

  // register reset values
  localparam logic [US_W-1:0]  MIN_PULSE_RST = 12'd1000;
  localparam logic [US_W-1:0]  MAX_PULSE_RST = 12'd2000;
  localparam logic [GAP_W-1:0] MAX_GAP_RST   = 16'd500;
  localparam logic [US_W-1:0]  IDLE_THR_RST  = 12'd1100;
  localparam logic [US_W-1:0]  FULL_THR_RST  = 12'd1900;
  localparam logic [US_W-1:0]  CENTER_FB_RST = 12'd1500;
  localparam logic [US_W-1:0]  FB_THRESH_RST = 12'd100;
  localparam logic [US_W-1:0]  CENTER_LR_RST = 12'd1500;

  localparam logic [US_W-1:0]  LR_NORMAL_DEADZONE = 12'd50;
  localparam logic [US_W-1:0]  LR_CONFIG_DEADZONE = 12'd150;
  localparam logic [PCT_W-1:0] PCT_FULL           = 7'd100;

endpackage

// ===== hw/rtl/rc_pwm_pulse_decoder_top.sv =====
// ----------------------------------------------------------------------------
// RC PWM pulse decoder
// Measures forward/back, left/right and throttle pulse widths from pin-change
// beats and reports the decoded stick state for every input beat.
//
//   channel   direction  handshake                payload
//   in        sink       in_valid_i / in_ready_o  opcode, channel, level, stamps
//   out       source     out_valid_o / out_ready_i percent, class, offset, flags
//   cfg       sink       cfg_we_i (no wait)       cfg_idx_i, cfg_data_i
//
// One beat at a time: 2-bit digit-serial stamp subtraction in ST_SHIFT, then
// ST_EVAL qualifies and stores the pulse, ST_CALC decodes and ST_DONE hands over
// to the output register, with ST_DIV running the percent divider in between
// when the throttle lies strictly between idle and full.
// Reset (asynchronous, active low) restores register defaults and state.
// A stalled result holds in the output register; the next beat is taken
// once the current one has moved into it.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_decoder_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic [rcpwm_pkg::CH_W-1:0]           channel_i,
  input  logic                                 level_i,
  input  logic [rcpwm_pkg::STAMP_W-1:0]        now_us_i,
  input  logic [rcpwm_pkg::STAMP_W-1:0]        now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rcpwm_pkg::PCT_W-1:0]          throttle_pct_o,
  output logic [1:0]                           forback_class_o,
  output logic signed [rcpwm_pkg::OFF_W-1:0]   leftright_offset_o,
  output logic                                 lr_in_normal_deadzone_o,
  output logic                                 lr_in_config_deadzone_o,
  output logic                                 signal_healthy_o,
  input  logic                                 cfg_we_i,
  input  logic [rcpwm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcpwm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = rcpwm_pkg::STAMP_W;
  localparam int unsigned DW = rcpwm_pkg::DIGIT_W;
  localparam int unsigned UW = rcpwm_pkg::US_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHIFT, ST_EVAL, ST_CALC, ST_DIV, ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [UW-1:0]                   min_pulse_q, max_pulse_q, idle_thr_q, full_thr_q;
  logic [UW-1:0]                   center_fb_q, fb_thresh_q, center_lr_q;
  logic [rcpwm_pkg::GAP_W-1:0]     max_gap_q;

  // channel state
  logic [SW-1:0]                   edge_start_q [rcpwm_pkg::NUM_CH];
  logic [UW-1:0]                   pw_q [rcpwm_pkg::NUM_CH];
  logic [SW-1:0]                   last_ms_q;

  // item in flight
  logic                            op_q, lvl_q;
  logic [rcpwm_pkg::CH_W-1:0]      ch_q;
  logic [SW-1:0]                   a_q, b_q, c_q, d_q;
  logic [rcpwm_pkg::DIG_CNT_W-1:0] dcnt_q;
  logic [SW-1:0]                   start_rd;

  // working result and output register
  logic [rcpwm_pkg::PCT_W-1:0]     pct_q, out_pct_q;
  logic [1:0]                      cls_q, out_cls_q;
  logic [rcpwm_pkg::OFF_W-1:0]     lr_q, out_lr_q;
  logic                            nd_q, cd_q, healthy_q;
  logic                            out_nd_q, out_cd_q, out_healthy_q, out_valid_q;

  logic                            accept, load, step, hand_over;
  logic [SW-1:0]                   diff_us, age_ms;
  logic                            bor_us, bor_ms;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept;
  assign step       = (state_q == ST_SHIFT);
  assign hand_over  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (channel_i)
      rcpwm_pkg::CH_FORBACK:   start_rd = edge_start_q[0];
      rcpwm_pkg::CH_LEFTRIGHT: start_rd = edge_start_q[1];
      rcpwm_pkg::CH_THROTTLE:  start_rd = edge_start_q[2];
      default:                 start_rd = '0;
    endcase
  end

  rcpwm_digit_sub u_sub_us (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (load),
    .step_i   (step),
    .a_i      (a_q[DW-1:0]),
    .b_i      (b_q[DW-1:0]),
    .diff_o   (diff_us),
    .borrow_o (bor_us)
  );

  rcpwm_digit_sub u_sub_ms (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (load),
    .step_i   (step),
    .a_i      (c_q[DW-1:0]),
    .b_i      (d_q[DW-1:0]),
    .diff_o   (age_ms),
    .borrow_o (bor_ms)
  );

  // qualify the falling edge once the difference is complete
  logic          is_evt, take, take_thr, age_ok, health_d;
  logic [UW-1:0] width;

  always_comb begin
    is_evt   = (op_q == rcpwm_pkg::OP_EVENT) && (ch_q <= rcpwm_pkg::CH_THROTTLE);
    width    = diff_us[UW-1:0];
    take     = is_evt && !lvl_q && !bor_us && (|diff_us) && (diff_us[SW-1:UW] == '0)
               && (width <= max_pulse_q) && (width >= min_pulse_q);
    take_thr = take && (ch_q == rcpwm_pkg::CH_THROTTLE);
    age_ok   = (age_ms[SW-1:rcpwm_pkg::GAP_W] == '0)
               && (age_ms[rcpwm_pkg::GAP_W-1:0] <= max_gap_q);
    // a fresh throttle pulse has age zero; only a zero stamp marks it unseen
    health_d = take_thr ? (|c_q) : ((|last_ms_q) && age_ok);
  end

  // decode the stored widths
  logic [UW-1:0]                   tw, mag;
  logic                            need_div;
  logic [rcpwm_pkg::PCT_W-1:0]     pct_sat;
  logic signed [UW+1:0]            fb_off, fb_thr;
  logic [rcpwm_pkg::OFF_W-1:0]     lr_d;
  logic [1:0]                      cls_d;
  logic [rcpwm_pkg::MUL_W-1:0]     div_num;
  logic [UW-1:0]                   div_den;
  logic                            div_start, div_done;
  logic [rcpwm_pkg::PCT_W-1:0]     div_quot;

  always_comb begin
    tw       = pw_q[2];
    need_div = (tw < full_thr_q) && (tw > idle_thr_q);
    pct_sat  = (tw >= full_thr_q) ? rcpwm_pkg::PCT_FULL : '0;
    div_num  = rcpwm_pkg::MUL_W'(tw - idle_thr_q) * rcpwm_pkg::MUL_W'(rcpwm_pkg::PCT_FULL);
    div_den  = full_thr_q - idle_thr_q;

    fb_off = $signed({2'b00, pw_q[0]}) - $signed({2'b00, center_fb_q});
    fb_thr = $signed({2'b00, fb_thresh_q});
    if (fb_off > fb_thr) begin
      cls_d = rcpwm_pkg::CLS_FORWARD;
    end else if (fb_off < -fb_thr) begin
      cls_d = rcpwm_pkg::CLS_BACKWARD;
    end else begin
      cls_d = rcpwm_pkg::CLS_NEUTRAL;
    end

    lr_d = {1'b0, pw_q[1]} - {1'b0, center_lr_q};
    mag  = lr_d[rcpwm_pkg::OFF_W-1] ? UW'(-lr_d) : lr_d[UW-1:0];
  end

  assign div_start = (state_q == ST_CALC) && need_div;

  rcpwm_pct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // configuration and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q <= rcpwm_pkg::MIN_PULSE_RST;
      max_pulse_q <= rcpwm_pkg::MAX_PULSE_RST;
      max_gap_q   <= rcpwm_pkg::MAX_GAP_RST;
      idle_thr_q  <= rcpwm_pkg::IDLE_THR_RST;
      full_thr_q  <= rcpwm_pkg::FULL_THR_RST;
      center_fb_q <= rcpwm_pkg::CENTER_FB_RST;
      fb_thresh_q <= rcpwm_pkg::FB_THRESH_RST;
      center_lr_q <= rcpwm_pkg::CENTER_LR_RST;
      for (int i = 0; i < rcpwm_pkg::NUM_CH; i++) begin
        edge_start_q[i] <= '0;
        pw_q[i]         <= rcpwm_pkg::MIN_PULSE_RST;
      end
      last_ms_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rcpwm_pkg::CFG_MIN_PULSE: min_pulse_q <= cfg_data_i[UW-1:0];
          rcpwm_pkg::CFG_MAX_PULSE: max_pulse_q <= cfg_data_i[UW-1:0];
          rcpwm_pkg::CFG_MAX_GAP:   max_gap_q   <= cfg_data_i;
          rcpwm_pkg::CFG_IDLE_THR:  idle_thr_q  <= cfg_data_i[UW-1:0];
          rcpwm_pkg::CFG_FULL_THR:  full_thr_q  <= cfg_data_i[UW-1:0];
          rcpwm_pkg::CFG_CENTER_FB: center_fb_q <= cfg_data_i[UW-1:0];
          rcpwm_pkg::CFG_FB_THRESH: fb_thresh_q <= cfg_data_i[UW-1:0];
          rcpwm_pkg::CFG_CENTER_LR: center_lr_q <= cfg_data_i[UW-1:0];
          default: ;
        endcase
      end
      // rising edge: record the pulse start
      if (accept && (opcode_i == rcpwm_pkg::OP_EVENT) && level_i
          && (channel_i <= rcpwm_pkg::CH_THROTTLE)) begin
        edge_start_q[channel_i] <= now_us_i;
      end
      if ((state_q == ST_EVAL) && take) begin
        pw_q[ch_q] <= width;
        if (take_thr) begin
          last_ms_q <= c_q;
        end
      end
    end
  end

  // operand shift registers; the ms stamp rotates so it is whole again at the end
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q  <= opcode_i;
      ch_q  <= channel_i;
      lvl_q <= level_i;
      a_q   <= now_us_i;
      b_q   <= start_rd;
      c_q   <= now_ms_i;
      d_q   <= last_ms_q;
    end else if (step) begin
      a_q <= a_q >> DW;
      b_q <= b_q >> DW;
      c_q <= {c_q[DW-1:0], c_q[SW-1:DW]};
      d_q <= d_q >> DW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hand_over) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            dcnt_q  <= '0;
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == rcpwm_pkg::DIG_CNT_W'(rcpwm_pkg::NUM_DIGITS - 1)) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          healthy_q <= health_d;
          state_q   <= ST_CALC;
        end
        ST_CALC: begin
          cls_q <= cls_d;
          lr_q  <= lr_d;
          nd_q  <= (mag < rcpwm_pkg::LR_NORMAL_DEADZONE);
          cd_q  <= (mag < rcpwm_pkg::LR_CONFIG_DEADZONE);
          pct_q <= pct_sat;
          state_q <= need_div ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_done) begin
            pct_q   <= div_quot;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hand over once the output register is free
          if (hand_over) begin
            out_pct_q     <= pct_q;
            out_cls_q     <= cls_q;
            out_lr_q      <= lr_q;
            out_nd_q      <= nd_q;
            out_cd_q      <= cd_q;
            out_healthy_q <= healthy_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o             = out_valid_q;
  assign throttle_pct_o          = out_pct_q;
  assign forback_class_o         = out_cls_q;
  assign leftright_offset_o      = $signed(out_lr_q);
  assign lr_in_normal_deadzone_o = out_nd_q;
  assign lr_in_config_deadzone_o = out_cd_q;
  assign signal_healthy_o        = out_healthy_q;

endmodule

// ===== hw/rtl/rcpwm_digit_sub.sv =====
// ----------------------------------------------------------------------------
// RC pulse decoder digit-serial subtractor
// Subtracts two stamps one digit per cycle while step_i is high, LSB first, and
// collects the difference in a shift register together with the final borrow.
// ----------------------------------------------------------------------------
module rcpwm_digit_sub (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic                                step_i,
  input  logic [rcpwm_pkg::DIGIT_W-1:0]       a_i,
  input  logic [rcpwm_pkg::DIGIT_W-1:0]       b_i,
  output logic [rcpwm_pkg::STAMP_W-1:0]       diff_o,
  output logic                                borrow_o
);

  logic [rcpwm_pkg::STAMP_W-1:0] diff_q;
  logic                          borrow_q;
  logic [rcpwm_pkg::DIGIT_W:0]   dig_sum;

  assign dig_sum = {1'b0, a_i} - {1'b0, b_i} - {{rcpwm_pkg::DIGIT_W{1'b0}}, borrow_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b0;
    end else if (clear_i) begin
      borrow_q <= 1'b0;
    end else if (step_i) begin
      borrow_q <= dig_sum[rcpwm_pkg::DIGIT_W];
    end
  end

  // shift the new digit in at the top; after all digits it sits in place
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      diff_q <= {dig_sum[rcpwm_pkg::DIGIT_W-1:0],
                 diff_q[rcpwm_pkg::STAMP_W-1:rcpwm_pkg::DIGIT_W]};
    end
  end

  assign diff_o   = diff_q;
  assign borrow_o = borrow_q;

endmodule

// ===== hw/rtl/rcpwm_pct_div.sv =====
// ----------------------------------------------------------------------------
// RC pulse decoder percent divider
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rcpwm_pct_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rcpwm_pkg::MUL_W-1:0]       num_i,
  input  logic [rcpwm_pkg::US_W-1:0]        den_i,
  output logic                              done_o,
  output logic [rcpwm_pkg::PCT_W-1:0]       quot_o
);

  logic [rcpwm_pkg::MUL_W-1:0]     rem_q;
  logic [rcpwm_pkg::MUL_W-1:0]     dsh_q;
  logic [rcpwm_pkg::PCT_W-1:0]     quot_q;
  logic [rcpwm_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                            busy_q;
  logic                            done_q;
  logic                            ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rcpwm_pkg::DIV_CNT_W'(rcpwm_pkg::PCT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= {1'b0, den_i, {(rcpwm_pkg::PCT_W-1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[rcpwm_pkg::PCT_W-2:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/rcpwm_checker.sv =====
// ----------------------------------------------------------------------------
// RC pulse decoder port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module rcpwm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [rcpwm_pkg::PCT_W-1:0]        throttle_pct_o,
  input logic [1:0]                         forback_class_o,
  input logic                               lr_in_normal_deadzone_o,
  input logic                               lr_in_config_deadzone_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one beat in flight: no new beat right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in flight");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (throttle_pct_o <= rcpwm_pkg::PCT_FULL)
                    && (forback_class_o <= rcpwm_pkg::CLS_BACKWARD))
    else $error("result field out of range");

  // the normal dead-zone lies inside the configured one
  a_deadzone_nest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lr_in_normal_deadzone_o |-> lr_in_config_deadzone_o)
    else $error("dead-zone flags inconsistent");

endmodule

bind rc_pwm_pulse_decoder_top rcpwm_checker u_rcpwm_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .in_valid_i              (in_valid_i),
  .in_ready_o              (in_ready_o),
  .out_valid_o             (out_valid_o),
  .out_ready_i             (out_ready_i),
  .throttle_pct_o          (throttle_pct_o),
  .forback_class_o         (forback_class_o),
  .lr_in_normal_deadzone_o (lr_in_normal_deadzone_o),
  .lr_in_config_deadzone_o (lr_in_config_deadzone_o)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// RC PWM pulse decoder testbench
// Drives pin-change and poll beats with random gaps, stalls the result side at
// random, and checks every result against an in-bench model of the three
// width channels, the throttle percent, the stick classes and the link health.
// ----------------------------------------------------------------------------
module tb_top;
  import rcpwm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_BEATS    = 128;

  // channel code with no channel behind it
  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [1:0]       cls;
    logic [OFF_W-1:0] off;
    logic             nd;
    logic             cd;
    logic             healthy;
  } stick_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 opcode = OP_POLL;
  logic [CH_W-1:0]      channel = CH_FORBACK;
  logic                 level = 1'b0;
  logic [STAMP_W-1:0]   now_us = '0;
  logic [STAMP_W-1:0]   now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PCT_W-1:0]     throttle_pct;
  logic [1:0]           forback_class;
  logic signed [OFF_W-1:0] leftright_offset;
  logic                 lr_normal_dz;
  logic                 lr_config_dz;
  logic                 signal_healthy;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register mirror
  logic [US_W-1:0]  min_pulse = MIN_PULSE_RST;
  logic [US_W-1:0]  max_pulse = MAX_PULSE_RST;
  logic [GAP_W-1:0] gap_limit = MAX_GAP_RST;
  logic [US_W-1:0]  idle_thr  = IDLE_THR_RST;
  logic [US_W-1:0]  full_thr  = FULL_THR_RST;
  logic [US_W-1:0]  center_fb = CENTER_FB_RST;
  logic [US_W-1:0]  fb_thresh = FB_THRESH_RST;
  logic [US_W-1:0]  center_lr = CENTER_LR_RST;

  // channel state mirror
  logic [STAMP_W-1:0] rise_us [NUM_CH];
  logic [US_W-1:0]    width_us [NUM_CH];
  logic [STAMP_W-1:0] thr_last_ms = '0;

  stick_t         sticks_due[$];
  stick_t         due;
  int             mismatches = 0;
  int             beats_sent = 0;
  int             out_stall = 0;
  int             quiet_cycles = 0;
  bit             no_idle = 1'b0;
  logic [STAMP_W-1:0] us_clk;
  logic [STAMP_W-1:0] ms_clk;

  rc_pwm_pulse_decoder_top dut (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_ready_o              (in_ready),
    .opcode_i                (opcode),
    .channel_i               (channel),
    .level_i                 (level),
    .now_us_i                (now_us),
    .now_ms_i                (now_ms),
    .out_valid_o             (out_valid),
    .out_ready_i             (out_ready),
    .throttle_pct_o          (throttle_pct),
    .forback_class_o         (forback_class),
    .leftright_offset_o      (leftright_offset),
    .lr_in_normal_deadzone_o (lr_normal_dz),
    .lr_in_config_deadzone_o (lr_config_dz),
    .signal_healthy_o        (signal_healthy),
    .cfg_we_i                (cfg_we),
    .cfg_idx_i               (cfg_idx),
    .cfg_data_i              (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the channel state by one beat and return the decoded sticks.
  function automatic stick_t decode_beat(input logic op, input logic [CH_W-1:0] ch,
                                         input logic lvl, input logic [STAMP_W-1:0] us,
                                         input logic [STAMP_W-1:0] ms);
    logic [STAMP_W-1:0] w;
    int unsigned        tw;
    int unsigned        pct;
    int                 off;
    int                 lr;
    int                 mag;
    stick_t             r;
    if (op == OP_EVENT && ch < NUM_CH) begin
      if (lvl) begin
        rise_us[ch] = us;
      end else if (us > rise_us[ch]) begin
        w = us - rise_us[ch];
        if (w <= max_pulse && w >= min_pulse) begin
          width_us[ch] = w[US_W-1:0];
          if (ch == CH_THROTTLE) thr_last_ms = ms;
        end
      end
    end

    tw = width_us[CH_THROTTLE];
    if (tw >= full_thr) pct = PCT_FULL;
    else if (tw <= idle_thr) pct = 0;
    else pct = ((tw - idle_thr) * PCT_FULL) / (full_thr - idle_thr);
    r.pct = pct[PCT_W-1:0];

    off = int'(width_us[CH_FORBACK]) - int'(center_fb);
    if (off > int'(fb_thresh)) r.cls = CLS_FORWARD;
    else if (off < -int'(fb_thresh)) r.cls = CLS_BACKWARD;
    else r.cls = CLS_NEUTRAL;

    lr = int'(width_us[CH_LEFTRIGHT]) - int'(center_lr);
    mag = (lr < 0) ? -lr : lr;
    r.off = lr[OFF_W-1:0];
    r.nd = (mag < int'(LR_NORMAL_DEADZONE));
    r.cd = (mag < int'(LR_CONFIG_DEADZONE));

    // zero stamp reads as never seen; age wraps mod 2^32
    if (thr_last_ms == '0) r.healthy = 1'b0;
    else r.healthy = ((ms - thr_last_ms) <= gap_limit);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("decoder mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic send_beat(input logic op, input logic [CH_W-1:0] ch, input logic lvl,
                           input logic [STAMP_W-1:0] us, input logic [STAMP_W-1:0] ms);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    channel  <= ch;
    level    <= lvl;
    now_us   <= us;
    now_ms   <= ms;
    do @(posedge clk); while (in_ready !== 1'b1);
    sticks_due.push_back(decode_beat(op, ch, lvl, us, ms));
    beats_sent++;
  endtask

  task automatic send_pulse(input logic [CH_W-1:0] ch, input logic [STAMP_W-1:0] start,
                            input int unsigned width, input logic [STAMP_W-1:0] ms);
    logic [STAMP_W-1:0] stop_us;
    stop_us = start + width;
    send_beat(OP_EVENT, ch, 1'b1, start, ms);
    send_beat(OP_EVENT, ch, 1'b0, stop_us, ms);
  endtask

  // Drop valid, wait for every result, then let the pipeline settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (sticks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_PULSE: min_pulse = data[US_W-1:0];
      CFG_MAX_PULSE: max_pulse = data[US_W-1:0];
      CFG_MAX_GAP:   gap_limit = data;
      CFG_IDLE_THR:  idle_thr  = data[US_W-1:0];
      CFG_FULL_THR:  full_thr  = data[US_W-1:0];
      CFG_CENTER_FB: center_fb = data[US_W-1:0];
      CFG_FB_THRESH: fb_thresh = data[US_W-1:0];
      CFG_CENTER_LR: center_lr = data[US_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // 12-bit registers get junk in the upper nibble; the block must drop it.
  task automatic apply_setting(input int unsigned mn, input int unsigned mx,
                               input int unsigned gap, input int unsigned idle,
                               input int unsigned full, input int unsigned cfb,
                               input int unsigned thr, input int unsigned clr);
    drain();
    write_reg(CFG_MIN_PULSE, {4'($urandom_range(0, 15)), 12'(mn)});
    write_reg(CFG_MAX_PULSE, {4'($urandom_range(0, 15)), 12'(mx)});
    write_reg(CFG_MAX_GAP,   16'(gap));
    write_reg(CFG_IDLE_THR,  {4'($urandom_range(0, 15)), 12'(idle)});
    write_reg(CFG_FULL_THR,  {4'($urandom_range(0, 15)), 12'(full)});
    write_reg(CFG_CENTER_FB, {4'($urandom_range(0, 15)), 12'(cfb)});
    write_reg(CFG_FB_THRESH, {4'($urandom_range(0, 15)), 12'(thr)});
    write_reg(CFG_CENTER_LR, {4'($urandom_range(0, 15)), 12'(clr)});
  endtask

  // Mostly well-formed rise/fall pairs around the accept window, plus noise.
  task automatic run_traffic(input int count, input bit allow_idle);
    int             n;
    int             iter;
    int             pick;
    int             lo;
    int             hi;
    int unsigned    width;
    logic [CH_W-1:0] ch;
    n = 0;
    iter = 0;
    while (n < count) begin
      if (!allow_idle) no_idle = 1'b1;
      else if (iter % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      iter++;
      if ($urandom_range(0, 49) == 0) us_clk = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      if ($urandom_range(0, 59) == 0) ms_clk = 32'hFFFF_FFFF - $urandom_range(0, 400);
      ms_clk += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 200);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        ch = CH_W'($urandom_range(0, 2));
        lo = int'(min_pulse) - 40;
        hi = int'(max_pulse) + 40;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        if (lo <= hi && $urandom_range(0, 4) != 0) width = $urandom_range(lo, hi);
        else width = $urandom_range(0, 4095);
        us_clk += $urandom_range(1, 3000);
        send_pulse(ch, us_clk, width, ms_clk);
        us_clk += width;
        n += 2;
      end else if (pick < 75) begin
        // lone edge, breaks the pairing
        send_beat(OP_EVENT, CH_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                  us_clk + $urandom_range(0, 4095), ms_clk);
        n++;
      end else if (pick < 85) begin
        send_beat(OP_POLL, CH_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                  ms_clk + $urandom_range(0, 1000));
        n++;
      end else if (pick < 92) begin
        send_beat(OP_EVENT, CH_NONE, 1'($urandom_range(0, 1)), $urandom, $urandom);
        n++;
      end else begin
        send_beat(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), $urandom, $urandom);
        n++;
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_pulse_corners;
    send_beat(OP_POLL, CH_FORBACK, 1'b0, 32'd0, 32'd0);
    send_pulse(CH_THROTTLE, 32'd100, 1500, 32'd1000);
    send_pulse(CH_FORBACK, 32'd0, 1000, 32'd1001);         // width at min
    send_pulse(CH_FORBACK, 32'd5000, 2000, 32'd1002);      // width at max
    send_pulse(CH_FORBACK, 32'd10000, 999, 32'd1003);      // just under min
    send_pulse(CH_LEFTRIGHT, 32'd20000, 2001, 32'd1004);   // just over max
    send_pulse(CH_LEFTRIGHT, 32'd30000, 1500, 32'd1005);
    send_beat(OP_EVENT, CH_LEFTRIGHT, 1'b0, 32'd30000, 32'd1006);  // equal stamp
    send_pulse(CH_LEFTRIGHT, 32'hFFFF_FF00, 32'h200, 32'd1007);    // wrapped stamp
    send_beat(OP_EVENT, CH_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_EVENT, CH_NONE, 1'b0, 32'd0, 32'd0);
    send_pulse(CH_THROTTLE, 32'hFFFF_F000, 1900, 32'd0);   // good pulse, zero stamp
    send_pulse(CH_THROTTLE, 32'd1000, 1200, 32'hFFFF_FFFF);
    send_beat(OP_POLL, CH_THROTTLE, 1'b0, 32'd0, 32'd499); // age right at the limit
    send_beat(OP_POLL, CH_THROTTLE, 1'b0, 32'd0, 32'd500); // one past it
    send_beat(OP_POLL, CH_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_window_settings;
    apply_setting(1000, 2000, 500, 1100, 1900, 1500, 100, 1500);
    run_traffic(PHASE_BEATS, 1'b1);
    apply_setting(0, 4095, 16'hFFFF, 0, 4095, 0, 0, 0);
    run_traffic(PHASE_BEATS, 1'b1);
    apply_setting(4095, 0, 0, 4095, 0, 4095, 4095, 4095);
    run_traffic(PHASE_BEATS, 1'b1);
    apply_setting(1200, 1200, 100, 1600, 1400, 2000, 50, 1000);
    run_traffic(PHASE_BEATS, 1'b1);
    apply_setting(800, 2200, 1000, 1500, 1500, 1500, 0, 1500);
    run_traffic(PHASE_BEATS, 1'b1);
    repeat (2) begin
      apply_setting($urandom_range(0, 2000), $urandom_range(1500, 4095),
                    $urandom_range(0, 2000), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 600), $urandom_range(0, 4095));
      run_traffic(PHASE_BEATS, 1'b1);
    end
  endtask

  task automatic test_back_to_back;
    apply_setting(900, 2100, 300, 1100, 1900, 1500, 100, 1500);
    run_traffic(PHASE_BEATS, 1'b0);
  endtask

  // result side: stall draw per beat, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (sticks_due.size() == 0) begin
        report_mismatch("result with nothing expected", 1, 0);
      end else begin
        due = sticks_due.pop_front();
        if (throttle_pct !== due.pct)
          report_mismatch("throttle_pct", int'(throttle_pct), int'(due.pct));
        if (forback_class !== due.cls)
          report_mismatch("forback_class", int'(forback_class), int'(due.cls));
        if (leftright_offset !== $signed(due.off))
          report_mismatch("leftright_offset", int'(leftright_offset), int'($signed(due.off)));
        if (lr_normal_dz !== due.nd)
          report_mismatch("lr_in_normal_deadzone", int'(lr_normal_dz), int'(due.nd));
        if (lr_config_dz !== due.cd)
          report_mismatch("lr_in_config_deadzone", int'(lr_config_dz), int'(due.cd));
        if (signal_healthy !== due.healthy)
          report_mismatch("signal_healthy", int'(signal_healthy), int'(due.healthy));
      end
      out_stall = no_idle ? 0 : $urandom_range(0, 10);
    end
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rc_pwm_pulse_decoder_top test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      rise_us[i]  = '0;
      width_us[i] = MIN_PULSE_RST;
    end
    us_clk = $urandom;
    ms_clk = 32'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_pulse_corners();
    test_window_settings();
    test_back_to_back();
    drain();
    if (mismatches == 0) begin
      $display("rc_pwm_pulse_decoder_top test passed");
    end else begin
      $display("rc_pwm_pulse_decoder_top test failed");
    end
    $finish;
  end

endmodule
